[src/att_pkg.sv]
// Package for the ANSI text terminal: operation codes, queue entry types,
// character constants and the SGR color table. No dependencies.
package att_pkg;

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_READ  = 4'd1;
  localparam logic [3:0] OP_PUT   = 4'd2;
  localparam logic [3:0] OP_BS    = 4'd3;
  localparam logic [3:0] OP_NL    = 4'd4;
  localparam logic [3:0] OP_TAB   = 4'd5;
  localparam logic [3:0] OP_SGR   = 4'd6;
  localparam logic [3:0] OP_CLEAR = 4'd7;
  localparam logic [3:0] OP_ERASE = 4'd8;
  localparam logic [3:0] OP_HOME  = 4'd9;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic [7:0] ATTR_RST = 8'h07;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic       use_def;
    logic       fg_v;
    logic [2:0] fg;
    logic       bg_v;
    logic [2:0] bg;
  } sgr_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  echo;
    logic [7:0]  chr;
    logic [10:0] idx;
    logic [4:0]  hrow;
    logic [6:0]  hcol;
    sgr_t        sgr;
  } entry_t;

  function automatic logic [2:0] ansi_colour(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

[src/att_if.sv]
// Channel interfaces of the ANSI text terminal: input items and results.
// Depends on nothing.
interface att_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  modport source (output valid, cmd, char_code, cell_index, input ready);
  modport sink (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface att_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_char;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [7:0]  attribute;
  logic        cursor_update;
  logic [15:0] cell_data;
  modport source (output valid, echo_char, cursor_col, cursor_row, attribute,
                  cursor_update, cell_data, input ready);
  modport sink (input valid, echo_char, cursor_col, cursor_row, attribute,
                cursor_update, cell_data, output ready);
endinterface

[src/att_front.sv]
// Front end: accepts input items, runs the escape parser and turns each item
// into one queue entry. Depends on att_pkg and att_if.
module att_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int MAX_CSI_VALUES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  att_in_if.sink          in_if,
  input  logic            init_busy,
  input  logic            q_full,
  output logic            q_push,
  output att_pkg::entry_t q_data
);
  localparam int SW = $clog2(MAX_CSI_VALUES);
  localparam logic [1:0] M_NORMAL = 2'd0;
  localparam logic [1:0] M_ESC    = 2'd1;
  localparam logic [1:0] M_CSI    = 2'd2;
  localparam logic [1:0] F_ACC  = 2'd0;
  localparam logic [1:0] F_WALK = 2'd1;
  localparam logic [1:0] F_EMIT = 2'd2;

  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    fst_r, fst_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   csi_r [MAX_CSI_VALUES];
  logic [15:0]   csi_nxt [MAX_CSI_VALUES];
  att_pkg::sgr_t sum_r, sum_nxt;
  logic          accept;
  logic [7:0]    c;
  logic [19:0]   acc;
  logic [15:0]   p, colv, rowv;

  assign in_if.ready = (fst_r == F_ACC) && !q_full && !init_busy;
  assign accept = in_if.valid && in_if.ready;
  assign c = in_if.char_code;

  always_comb begin
    mode_nxt = mode_r;
    fst_nxt  = fst_r;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    for (int i = 0; i < MAX_CSI_VALUES; i++) csi_nxt[i] = csi_r[i];
    q_push = 1'b0;
    q_data = '0;
    acc = ({4'd0, csi_r[slot_r]} << 3) + ({4'd0, csi_r[slot_r]} << 1)
        + 20'(c - att_pkg::CH_ZERO);
    colv = (csi_r[1] == 16'd0) ? 16'd0 : csi_r[1] - 16'd1;
    rowv = (csi_r[0] == 16'd0) ? 16'd0 : csi_r[0] - 16'd1;
    p = csi_r[0];
    case (fst_r)
      F_ACC: begin
        if (accept) begin
          q_push = 1'b1;
          q_data.op = att_pkg::OP_NOP;
          q_data.idx = in_if.cell_index;
          q_data.chr = c;
          if (in_if.cmd) begin
            q_data.op = att_pkg::OP_READ;
          end else begin
            case (mode_r)
              M_NORMAL: begin
                if (c == att_pkg::CH_ESC) begin
                  mode_nxt = M_ESC;
                end else begin
                  q_data.echo = c;
                  if (c == att_pkg::CH_BS) q_data.op = att_pkg::OP_BS;
                  else if (c == att_pkg::CH_NL) q_data.op = att_pkg::OP_NL;
                  else if (c == att_pkg::CH_TAB) q_data.op = att_pkg::OP_TAB;
                  else if (c >= att_pkg::CH_SPACE) q_data.op = att_pkg::OP_PUT;
                end
              end
              M_ESC: begin
                mode_nxt = (c == att_pkg::CH_LBRK) ? M_CSI : M_NORMAL;
              end
              default: begin
                if (c >= att_pkg::CH_ZERO && c <= att_pkg::CH_NINE) begin
                  csi_nxt[slot_r] = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                end else if (c == att_pkg::CH_SEMI) begin
                  if (32'(slot_r) + 1 < MAX_CSI_VALUES) slot_nxt = slot_r + 1'b1;
                end else begin
                  mode_nxt = M_NORMAL;
                  slot_nxt = '0;
                  if (c == att_pkg::CH_M) begin
                    q_push = 1'b0;
                    fst_nxt = F_WALK;
                    cnt_nxt = slot_r;
                    sum_nxt = '0;
                  end else begin
                    for (int i = 0; i < MAX_CSI_VALUES; i++) csi_nxt[i] = 16'd0;
                    if (c == att_pkg::CH_J && csi_r[0] == 16'd2) begin
                      q_data.op = att_pkg::OP_CLEAR;
                    end else if (c == att_pkg::CH_K && csi_r[0] == 16'd0) begin
                      q_data.op = att_pkg::OP_ERASE;
                    end else if (c == att_pkg::CH_H) begin
                      q_data.op = att_pkg::OP_HOME;
                      q_data.hcol = (colv > 16'(COLS - 1)) ? 7'(COLS - 1) : colv[6:0];
                      q_data.hrow = (rowv > 16'(ROWS - 1)) ? 5'(ROWS - 1) : rowv[4:0];
                    end
                  end
                end
              end
            endcase
          end
        end
      end
      F_WALK: begin
        if (p == 16'd0) begin
          sum_nxt = '0;
          sum_nxt.use_def = 1'b1;
        end else if (p >= 16'd30 && p <= 16'd37) begin
          sum_nxt.fg_v = 1'b1;
          sum_nxt.fg = att_pkg::ansi_colour(p[2:0] - 3'd6);
        end else if (p >= 16'd40 && p <= 16'd47) begin
          sum_nxt.bg_v = 1'b1;
          sum_nxt.bg = att_pkg::ansi_colour(p[2:0]);
        end
        for (int i = 0; i < MAX_CSI_VALUES - 1; i++) csi_nxt[i] = csi_r[i + 1];
        csi_nxt[MAX_CSI_VALUES - 1] = 16'd0;
        if (cnt_r == '0) fst_nxt = F_EMIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      default: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data.op = att_pkg::OP_SGR;
          q_data.sgr = sum_r;
          fst_nxt = F_ACC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      fst_r  <= F_ACC;
      slot_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      for (int i = 0; i < MAX_CSI_VALUES; i++) csi_r[i] <= 16'd0;
    end else begin
      mode_r <= mode_nxt;
      fst_r  <= fst_nxt;
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      for (int i = 0; i < MAX_CSI_VALUES; i++) csi_r[i] <= csi_nxt[i];
    end
  end
endmodule

[src/att_queue.sv]
// Short queue of classified entries between the front and back ends.
// Depends on att_pkg.
module att_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  att_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output att_pkg::entry_t head,
  output logic            empty
);
  localparam int PW = $clog2(att_pkg::QDEPTH);

  att_pkg::entry_t mem_r [att_pkg::QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW + 1)'(att_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end
endmodule

[src/att_back.sv]
// Back end: holds the cell store, cursor and attribute, carries out queue
// entries and drives the result register. Depends on att_pkg and att_if.
module att_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            q_empty,
  input  att_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            init_busy,
  att_out_if.source       out_if
);
  localparam int CELLS = COLS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_BSW  = 3'd3;
  localparam logic [2:0] S_SCR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rdata_r;
  logic            we;
  logic [AW-1:0]   wa, ra;
  logic [15:0]     wd;

  logic [2:0]      st_r, st_nxt;
  logic [6:0]      col_r, col_nxt;
  logic [4:0]      row_r, row_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic [7:0]      dattr_r;
  att_pkg::entry_t e_r, e_nxt;
  logic [AW-1:0]   fp_r, fp_nxt, fe_r, fe_nxt, sp_r, sp_nxt, pa_r, pa_nxt;
  logic [15:0]     fd_r, fd_nxt, cell_r, cell_nxt;
  logic            pend_r, pend_nxt, init_r, init_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      o_echo_r, o_echo_nxt, o_attr_r, o_attr_nxt;
  logic [6:0]      o_col_r, o_col_nxt;
  logic [4:0]      o_row_r, o_row_nxt;
  logic            o_upd_r, o_upd_nxt;
  logic [15:0]     o_cell_r, o_cell_nxt;
  logic [AW-1:0]   cur_addr;
  logic [15:0]     blank;
  logic [7:0]      sgr_attr;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[ra];
  end

  assign cur_addr  = AW'(row_r) * COLS_A + AW'(col_r);
  assign blank     = {attr_r, att_pkg::CH_SPACE};
  assign init_busy = init_r;
  assign q_pop     = (st_r == S_IDLE) && !q_empty;

  always_comb begin
    sgr_attr = q_head.sgr.use_def ? dattr_r : attr_r;
    if (q_head.sgr.fg_v) sgr_attr[3:0] = {1'b0, q_head.sgr.fg};
    if (q_head.sgr.bg_v) sgr_attr[7:4] = {1'b0, q_head.sgr.bg};
  end

  always_comb begin
    st_nxt = st_r;
    col_nxt = col_r;
    row_nxt = row_r;
    attr_nxt = attr_r;
    e_nxt = e_r;
    fp_nxt = fp_r;
    fe_nxt = fe_r;
    fd_nxt = fd_r;
    sp_nxt = sp_r;
    pa_nxt = pa_r;
    pend_nxt = pend_r;
    init_nxt = init_r;
    cell_nxt = cell_r;
    ov_nxt = ov_r && !out_if.ready;
    o_echo_nxt = o_echo_r;
    o_col_nxt = o_col_r;
    o_row_nxt = o_row_r;
    o_attr_nxt = o_attr_r;
    o_upd_nxt = o_upd_r;
    o_cell_nxt = o_cell_r;
    we = 1'b0;
    wa = cur_addr;
    wd = blank;
    ra = sp_r;
    case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          e_nxt = q_head;
          st_nxt = S_DONE;
          cell_nxt = 16'd0;
          case (q_head.op)
            att_pkg::OP_READ: begin
              ra = AW'(q_head.idx);
              st_nxt = S_RD;
            end
            att_pkg::OP_PUT, att_pkg::OP_NL: begin
              if (q_head.op == att_pkg::OP_PUT) begin
                we = 1'b1;
                wd = {attr_r, q_head.chr};
              end
              if (q_head.op == att_pkg::OP_NL || col_r == 7'(COLS - 1)) begin
                col_nxt = 7'd0;
                if (row_r == 5'(ROWS - 1)) begin
                  sp_nxt = COLS_A;
                  pend_nxt = 1'b0;
                  st_nxt = S_SCR;
                end else begin
                  row_nxt = row_r + 5'd1;
                end
              end else begin
                col_nxt = col_r + 7'd1;
              end
            end
            att_pkg::OP_BS: begin
              if (col_r != 7'd0) begin
                col_nxt = col_r - 7'd1;
              end else if (row_r != 5'd0) begin
                row_nxt = row_r - 5'd1;
                col_nxt = 7'(COLS - 1);
              end
              st_nxt = S_BSW;
            end
            att_pkg::OP_TAB: begin
              col_nxt = ({1'b0, col_r} + 8'd3 > 8'(COLS - 1)) ? 7'(COLS - 1)
                      : col_r + 7'd3;
            end
            att_pkg::OP_SGR: begin
              attr_nxt = sgr_attr;
            end
            att_pkg::OP_CLEAR: begin
              fp_nxt = '0;
              fe_nxt = LAST_A;
              fd_nxt = blank;
              col_nxt = 7'd0;
              row_nxt = 5'd0;
              st_nxt = S_FILL;
            end
            att_pkg::OP_ERASE: begin
              fp_nxt = cur_addr;
              fe_nxt = AW'(row_r) * COLS_A + AW'(COLS - 1);
              fd_nxt = blank;
              st_nxt = S_FILL;
            end
            att_pkg::OP_HOME: begin
              col_nxt = q_head.hcol;
              row_nxt = q_head.hrow;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        cell_nxt = (32'(e_r.idx) < CELLS) ? rdata_r : 16'd0;
        st_nxt = S_DONE;
      end
      S_BSW: begin
        we = 1'b1;
        st_nxt = S_DONE;
      end
      S_SCR: begin
        if (pend_r) begin
          we = 1'b1;
          wa = pa_r;
          wd = rdata_r;
        end
        pend_nxt = 1'b1;
        pa_nxt = sp_r - COLS_A;
        if (sp_r == LAST_A) begin
          fp_nxt = AW'(CELLS - COLS);
          fe_nxt = LAST_A;
          fd_nxt = blank;
          st_nxt = S_FILL;
        end else begin
          sp_nxt = sp_r + 1'b1;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (pend_r) begin
          wa = pa_r;
          wd = rdata_r;
          pend_nxt = 1'b0;
        end else begin
          wa = fp_r;
          wd = fd_r;
          if (fp_r == fe_r) begin
            st_nxt = init_r ? S_IDLE : S_DONE;
            init_nxt = 1'b0;
          end else begin
            fp_nxt = fp_r + 1'b1;
          end
        end
      end
      default: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          o_echo_nxt = e_r.echo;
          o_col_nxt = col_r;
          o_row_nxt = row_r;
          o_attr_nxt = attr_r;
          o_upd_nxt = (e_r.op == att_pkg::OP_PUT) || (e_r.op == att_pkg::OP_BS)
                   || (e_r.op == att_pkg::OP_NL) || (e_r.op == att_pkg::OP_TAB)
                   || (e_r.op == att_pkg::OP_HOME);
          o_cell_nxt = cell_r;
          st_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_FILL;
      init_r  <= 1'b1;
      fp_r    <= '0;
      fe_r    <= LAST_A;
      fd_r    <= {att_pkg::ATTR_RST, att_pkg::CH_SPACE};
      pend_r  <= 1'b0;
      col_r   <= 7'd0;
      row_r   <= 5'd0;
      attr_r  <= att_pkg::ATTR_RST;
      dattr_r <= att_pkg::ATTR_RST;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      init_r  <= init_nxt;
      fp_r    <= fp_nxt;
      fe_r    <= fe_nxt;
      fd_r    <= fd_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      attr_r  <= attr_nxt;
      if (cfg_we) dattr_r <= cfg_wdata;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    sp_r     <= sp_nxt;
    pa_r     <= pa_nxt;
    cell_r   <= cell_nxt;
    o_echo_r <= o_echo_nxt;
    o_col_r  <= o_col_nxt;
    o_row_r  <= o_row_nxt;
    o_attr_r <= o_attr_nxt;
    o_upd_r  <= o_upd_nxt;
    o_cell_r <= o_cell_nxt;
  end

  assign out_if.valid         = ov_r;
  assign out_if.echo_char     = o_echo_r;
  assign out_if.cursor_col    = o_col_r;
  assign out_if.cursor_row    = o_row_r;
  assign out_if.attribute     = o_attr_r;
  assign out_if.cursor_update = o_upd_r;
  assign out_if.cell_data     = o_cell_r;
endmodule

[src/ansi_text_terminal_unit.sv]
// Top level of the ANSI text terminal: front parser, entry queue and back end.
// Depends on att_pkg, att_if, att_front, att_queue and att_back.
//
//   Channel  Direction  Handshake        Payload
//   in_if    input      valid / ready    cmd, char_code, cell_index
//   out_if   output     valid / ready    echo, cursor, attribute, update, cell
//   cfg      input      cfg_we           cfg_wdata (default attribute)
//
// A plain character, tab, cursor move or unhandled byte goes from idle straight to
// the result state in the back end, and a read or backspace passes through S_RD or
// S_BSW first; the back end handles one entry at a time, which sets the rate. A
// final m walks one parameter per cycle in the front end. A scroll copies each row
// up and blanks the last, a clear fills every cell and a line erase fills to the
// end of the line. After reset a clearing pass runs with in_if.ready low. The
// queue and the result register let either side stall without blocking the other.
module ansi_text_terminal_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int MAX_CSI_VALUES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  att_in_if.sink     in_if,
  att_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  logic            q_push, q_full, q_pop, q_empty, init_busy;
  att_pkg::entry_t q_data, q_head;

  att_front #(.COLS(COLS), .ROWS(ROWS), .MAX_CSI_VALUES(MAX_CSI_VALUES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .init_busy(init_busy),
    .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  att_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  att_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .init_busy(init_busy),
    .out_if(out_if)
  );
endmodule
